// ===== sv/ist_pkg.sv =====
package ist_pkg;

    // Table geometry
    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W    = 9;
    localparam int SAMPLE_W   = 32;
    localparam int WAVE_W     = 24;
    localparam int STEP_W     = 24;
    localparam int FRAC_W     = 24;
    localparam int PROD_W     = WAVE_W + STEP_W;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_WAVELENGTH = 2'd0;
    localparam logic [1:0] CFG_INVERSE_STEP     = 2'd1;
    localparam logic [1:0] CFG_POINT_COUNT      = 2'd2;

    // Configuration reset values
    localparam logic [WAVE_W-1:0]  START_RESET = '0;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 24'd65536;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Operation codes
    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_ACCUM  = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_READ   = 3'd3,
        OP_INTERP = 3'd4
    } op_t;

    // Input transaction
    typedef struct packed {
        logic [2:0]          operation;
        logic [7:0]          entry_index;
        logic [SAMPLE_W-1:0] sample_value;
        logic [WAVE_W-1:0]   query_wavelength;
    } ist_in_t;

    // Result transaction
    typedef struct packed {
        logic [SAMPLE_W-1:0] read_value;
        logic                in_range;
    } ist_out_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_ACC_RD,
        S_ACC_WR,
        S_CLEAR,
        S_RD,
        S_RD_OUT,
        S_MUL,
        S_CHECK,
        S_LO,
        S_HI,
        S_SUM
    } state_t;

    typedef enum logic [1:0] {
        ADDR_ITEM,
        ADDR_LO,
        ADDR_HI,
        ADDR_CLR
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_VALUE,
        WD_SUM,
        WD_ZERO
    } wdata_sel_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ENTRY,
        OUT_INTERP,
        OUT_ZERO
    } out_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        addr_sel_t  addr_sel;
        logic       we;
        wdata_sel_t wdata_sel;
        logic       clr_inc;
        logic       mul_en;
        logic       lo_en;
        logic       hi_en;
        out_sel_t   out_sel;
    } ist_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic ix_valid;
        logic interp_ok;
        logic clr_last;
    } ist_stat_t;

endpackage

// ===== sv/ist_ram.sv =====
module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ist_ctrl.sv =====
module ist_ctrl
    import ist_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [2:0] operation,
    input  ist_stat_t stat,
    output ist_ctrl_t ctrl,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_WRITE:  state_next = S_WRITE;
                        OP_ACCUM:  state_next = S_ACC_RD;
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_READ:   state_next = S_RD;
                        OP_INTERP: state_next = S_MUL;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:  state_next = S_IDLE;
            S_ACC_RD: state_next = S_ACC_WR;
            S_ACC_WR: state_next = S_IDLE;
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD:     state_next = S_RD_OUT;
            S_RD_OUT: state_next = S_IDLE;
            S_MUL:    state_next = S_CHECK;
            S_CHECK:  state_next = stat.interp_ok ? S_LO : S_IDLE;
            S_LO:     state_next = S_HI;
            S_HI:     state_next = S_SUM;
            S_SUM:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        ctrl           = '0;
        ctrl.addr_sel  = ADDR_ITEM;
        ctrl.wdata_sel = WD_VALUE;
        ctrl.out_sel   = OUT_NONE;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.load = start;
            end
            S_WRITE:
            begin
                ctrl.we = stat.ix_valid;
            end
            S_ACC_WR:
            begin
                ctrl.we        = stat.ix_valid;
                ctrl.wdata_sel = WD_SUM;
            end
            S_CLEAR:
            begin
                ctrl.addr_sel  = ADDR_CLR;
                ctrl.we        = 1'b1;
                ctrl.wdata_sel = WD_ZERO;
                ctrl.clr_inc   = 1'b1;
            end
            S_RD_OUT:
            begin
                ctrl.out_sel = stat.ix_valid ? OUT_ENTRY : OUT_ZERO;
            end
            S_MUL:
            begin
                ctrl.mul_en = 1'b1;
            end
            S_CHECK:
            begin
                ctrl.addr_sel = ADDR_LO;
                if (!stat.interp_ok)
                begin
                    ctrl.out_sel = OUT_ZERO;
                end
            end
            S_LO:
            begin
                ctrl.addr_sel = ADDR_HI;
                ctrl.lo_en    = 1'b1;
            end
            S_HI:
            begin
                ctrl.hi_en = 1'b1;
            end
            S_SUM:
            begin
                ctrl.out_sel = OUT_INTERP;
            end
            default:
            begin
                ctrl.addr_sel = ADDR_ITEM;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== sv/ist_datapath.sv =====
module ist_datapath
    import ist_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ist_in_t           cmd,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [STEP_W-1:0] cfg_data,
    input  ist_ctrl_t         ctrl,
    output ist_stat_t         stat,
    output logic              result_valid,
    output ist_out_t          result
);

    localparam logic [COUNT_W-1:0]  MAX_COUNT = COUNT_W'(MAX_POINTS);
    localparam logic [ADDR_W-1:0]   CLR_LAST  = ADDR_W'(MAX_POINTS - 1);
    localparam logic [FRAC_W:0]     ONE       = (FRAC_W+1)'(1) << FRAC_W;
    localparam logic [SAMPLE_W+FRAC_W+1:0] HALF =
        (SAMPLE_W+FRAC_W+2)'(1) << (FRAC_W - 1);

    // Configuration registers
    logic [WAVE_W-1:0]  start_wl_reg;
    logic [STEP_W-1:0]  inv_step_reg;
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_wl_reg <= START_RESET;
            inv_step_reg <= STEP_RESET;
            count_reg    <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_WAVELENGTH: start_wl_reg <= cfg_data[WAVE_W-1:0];
                CFG_INVERSE_STEP:     inv_step_reg <= cfg_data;
                CFG_POINT_COUNT:      count_reg    <= cfg_data[COUNT_W-1:0];
                default:              count_reg    <= count_reg;
            endcase
        end
    end

    // Latched transaction
    ist_in_t item_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            item_reg <= cmd;
        end
    end

    logic [COUNT_W-1:0] eff_count;
    assign eff_count = (count_reg > MAX_COUNT) ? MAX_COUNT : count_reg;
    assign stat.ix_valid = ({1'b0, item_reg.entry_index} < eff_count);

    // Clear sweep pointer
    logic [ADDR_W-1:0] clr_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg <= '0;
        end
        else if (ctrl.clr_inc)
        begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
        end
    end

    assign stat.clr_last = (clr_ptr_reg == CLR_LAST);

    // Wavelength offset times inverse step
    logic [WAVE_W:0]   diff;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;

    assign diff = {1'b0, item_reg.query_wavelength} - {1'b0, start_wl_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= diff[WAVE_W-1:0] * inv_step_reg;
            neg_reg  <= diff[WAVE_W];
        end
    end

    logic [PROD_W-FRAC_W-1:0] idx;
    logic [FRAC_W-1:0]        frac;

    assign idx  = prod_reg[PROD_W-1:FRAC_W];
    assign frac = prod_reg[FRAC_W-1:0];

    // Lower index must leave room for its upper neighbor
    assign stat.interp_ok = !neg_reg && (eff_count >= COUNT_W'(2))
        && (idx < (PROD_W-FRAC_W)'(eff_count - 1'b1));

    // Memory port
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W:0]   acc_sum;

    always_comb
    begin
        case (ctrl.addr_sel)
            ADDR_ITEM: ram_addr = item_reg.entry_index[ADDR_W-1:0];
            ADDR_LO:   ram_addr = idx[ADDR_W-1:0];
            ADDR_HI:   ram_addr = idx[ADDR_W-1:0] + 1'b1;
            ADDR_CLR:  ram_addr = clr_ptr_reg;
            default:   ram_addr = item_reg.entry_index[ADDR_W-1:0];
        endcase
    end

    // Saturating accumulate
    assign acc_sum = {1'b0, ram_rdata} + {1'b0, item_reg.sample_value};

    always_comb
    begin
        case (ctrl.wdata_sel)
            WD_VALUE: ram_wdata = item_reg.sample_value;
            WD_SUM:   ram_wdata = acc_sum[SAMPLE_W] ? '1 : acc_sum[SAMPLE_W-1:0];
            WD_ZERO:  ram_wdata = '0;
            default:  ram_wdata = '0;
        endcase
    end

    ist_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ctrl.we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Blend products, one per cycle
    logic [SAMPLE_W+FRAC_W:0]   lo_prod_reg;
    logic [SAMPLE_W+FRAC_W-1:0] hi_prod_reg;
    logic [SAMPLE_W+FRAC_W+1:0] blend;

    always_ff @(posedge clk)
    begin
        if (ctrl.lo_en)
        begin
            lo_prod_reg <= ram_rdata * (ONE - {1'b0, frac});
        end
        if (ctrl.hi_en)
        begin
            hi_prod_reg <= ram_rdata * frac;
        end
    end

    // Round to nearest, ties up
    assign blend = {1'b0, lo_prod_reg} + {2'b0, hi_prod_reg} + HALF;

    // Result register, one-cycle strobe
    logic     result_valid_reg;
    ist_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (ctrl.out_sel != OUT_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.out_sel)
            OUT_ENTRY:
            begin
                result_reg.read_value <= ram_rdata;
                result_reg.in_range   <= 1'b1;
            end
            OUT_INTERP:
            begin
                result_reg.read_value <= blend[FRAC_W+SAMPLE_W-1:FRAC_W];
                result_reg.in_range   <= 1'b1;
            end
            OUT_ZERO:
            begin
                result_reg.read_value <= '0;
                result_reg.in_range   <= 1'b0;
            end
            default:
            begin
                result_reg <= result_reg;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sv/interpolating_sample_table_unit.sv =====
// Interpolating sample table: 256 x 32-bit store of Q16.16 spectral samples.
// Command channel: a transaction is taken when start is high and busy is low;
// cmd carries operation, entry_index, sample_value and query_wavelength.
// Result channel: result_valid strobes for one cycle with result (read_value,
// in_range); the receiver cannot stall, so results are simply presented.
// The result strobe of an entry or interpolated read comes in the first cycle
// with busy low again. The single memory port means that the clear sweeps one
// entry per cycle, and the interpolated read fetches its two neighbors one
// after the other, with a registered multiply after each fetch. Unknown
// operations are dropped. Configuration (cfg_we, cfg_index, cfg_data) is a
// registered write, no wait. Reset clears the controller and restores
// start_wavelength 0, inverse_step 1/256 (65536 with 24 fraction bits) and
// point_count 256; the sample store is undefined until written or cleared.
module interpolating_sample_table_unit
    import ist_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ist_in_t           cmd,
    output logic              result_valid,
    output ist_out_t          result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [STEP_W-1:0] cfg_data
);

    ist_ctrl_t ctrl;
    ist_stat_t stat;

    ist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .stat      (stat),
        .ctrl      (ctrl),
        .busy      (busy)
    );

    ist_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    // A result only closes a transaction the controller was working on
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a transaction in progress");

    // Out-of-range results read as zero
    a_zero_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.in_range) |-> (result.read_value == '0))
        else $error("out-of-range result carries a nonzero value");

    // One transaction at a time: results never come back to back
    a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two results in consecutive cycles");

    // A clear is still busy once its first entry has been swept
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.operation == OP_CLEAR)) |=> ##1 busy)
        else $error("clear sweep ended early");

endmodule
